@@ sv/yenc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package yenc_pkg;

  // Width of the decoded byte counter and of the expected count register.
  localparam int COUNT_BITS = 24;
  localparam int CFG_BITS   = 24;
  // Compare width: room for the larger of the two plus a small offset.
  localparam int CMP_BITS   = ((COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS) + 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // A single raw byte causes at most this many results.
  localparam int MAX_RES  = 5;
  localparam int RES_BITS = 3;

  localparam logic [7:0] PLAIN_OFS = 8'd214;
  localparam logic [7:0] ESC_OFS   = 8'd150;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_EQ  = 8'h3D;

  localparam int MARKER_LEN = 6;
  localparam logic [7:0] END_MARKER [MARKER_LEN] = '{8'h3D, 8'h79, 8'h65, 8'h6E, 8'h64, 8'h20};

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_ESC        = 3'd1,
    MODE_AFTER_CR   = 3'd2,
    MODE_LINE_START = 3'd3,
    MODE_FIRST      = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_END_OK   = 2'd1,
    KIND_TOO_MANY = 2'd2,
    KIND_TOO_FEW  = 2'd3
  } kind_e;

  typedef struct packed {
    mode_e                 mode;
    logic [2:0]            match_pos;
    logic [COUNT_BITS-1:0] count;
    logic                  failed;
  } yenc_state_t;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } yenc_res_t;

  typedef struct packed {
    logic [RES_BITS-1:0]     n;
    yenc_res_t [MAX_RES-1:0] ent;
  } yenc_list_t;

endpackage

`default_nettype wire

@@ sv/yenc_body_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Decodes the body of a yEnc article from a stream of raw bytes, one byte per request,
// and yields decoded bytes (tuser 0), an end status (1 ok, 3 too few) or a too-many
// error (2); tlast marks the final result caused by one input byte. Results leave
// through a five-entry buffer at one per cycle while the receiver is ready; a byte
// with zero or one result is then taken every cycle, and one with n results (at most
// five, if a held end marker fails to match) holds off the next byte until all but
// its last have left. The user must write the expected count only while the block is
// idle (not enforced); the count survives the end marker, which resets decoding.
module yenc_body_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [yenc_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] in_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]                    m_axis_tuser,   // [1:0] kind
  output logic                          m_axis_tlast
);
  import yenc_pkg::*;

  logic [CFG_BITS-1:0] expected_q;
  yenc_state_t         state_q, state_d;
  yenc_list_t          list;
  yenc_res_t           res;
  logic                accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  yenc_step u_step (
    .in_byte_i  (s_axis_tdata),
    .state_i    (state_q),
    .expected_i (expected_q),
    .state_o    (state_d),
    .list_o     (list)
  );

  yenc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .list_i      (list),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = res.kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q        <= '0;
      state_q.mode      <= MODE_NORMAL;
      state_q.match_pos <= '0;
      state_q.count     <= '0;
      state_q.failed    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        expected_q <= cfg_wdata_i;
      end
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/yenc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module yenc_step (
  input  logic [7:0]                    in_byte_i,
  input  yenc_pkg::yenc_state_t         state_i,
  input  logic [yenc_pkg::CFG_BITS-1:0] expected_i,
  output yenc_pkg::yenc_state_t         state_o,
  output yenc_pkg::yenc_list_t          list_o
);
  import yenc_pkg::*;

  logic [7:0]          byte_plain;
  logic [7:0]          byte_esc;
  logic [2:0]          k;
  logic [7:0]          vals [MAX_RES];
  logic [RES_BITS-1:0] n_emit;
  logic                end_hit;
  logic [MAX_RES-1:0]  ok;
  logic [RES_BITS-1:0] d;
  logic                too_many;
  logic [CMP_BITS-1:0] exp_ext;
  logic [CMP_BITS-1:0] cnt_ext;
  logic [CMP_BITS-1:0] sum;
  logic [CMP_BITS-1:0] sat;
  logic [CMP_BITS-1:0] sum_d;
  logic [CMP_BITS-1:0] sat_d;

  assign byte_plain = in_byte_i + PLAIN_OFS;
  assign byte_esc   = in_byte_i + ESC_OFS;
  assign k          = (state_i.match_pos > 3'd5) ? 3'd5 : state_i.match_pos;
  assign exp_ext    = CMP_BITS'(expected_i);
  assign cnt_ext    = CMP_BITS'(state_i.count);

  // Mode update and the list of bytes that this input hands to the counter.
  always_comb begin
    state_o = state_i;
    n_emit  = '0;
    end_hit = 1'b0;
    for (int j = 0; j < MAX_RES; j++) begin
      vals[j] = '0;
    end
    unique case (state_i.mode)
      MODE_ESC: begin
        vals[0]      = byte_esc;
        n_emit       = RES_BITS'(1);
        state_o.mode = MODE_NORMAL;
      end
      MODE_AFTER_CR: begin
        state_o.mode      = MODE_LINE_START;
        state_o.match_pos = '0;
      end
      MODE_FIRST: begin
        if (in_byte_i == CH_EQ) begin
          state_o.mode = MODE_ESC;
        end else begin
          vals[0]      = byte_plain;
          n_emit       = RES_BITS'(1);
          state_o.mode = MODE_NORMAL;
        end
      end
      MODE_LINE_START: begin
        if (k == 3'd0 && in_byte_i == CH_DOT) begin
          state_o.mode = MODE_FIRST;
        end else if (in_byte_i == END_MARKER[k]) begin
          if (k == 3'd5) begin
            end_hit = 1'b1;
          end else begin
            state_o.match_pos = k + 3'd1;
          end
        end else begin
          state_o.match_pos = '0;
          state_o.mode      = MODE_NORMAL;
          if (k == 3'd0) begin
            vals[0] = byte_plain;
            n_emit  = RES_BITS'(1);
          end else if (k == 3'd1) begin
            vals[0] = byte_esc;
            n_emit  = RES_BITS'(1);
          end else begin
            // The held '=' escapes the held 'y'; the rest of the held marker is plain.
            vals[0] = END_MARKER[1] + ESC_OFS;
            for (int j = 1; j < MAX_RES - 1; j++) begin
              if (j < int'(k) - 1) begin
                vals[j] = END_MARKER[j+1] + PLAIN_OFS;
              end
            end
            n_emit = RES_BITS'(k - 3'd1);
            if (in_byte_i == CH_CR) begin
              state_o.mode = MODE_AFTER_CR;
            end else if (in_byte_i == CH_EQ) begin
              state_o.mode = MODE_ESC;
            end else begin
              for (int j = 1; j < MAX_RES; j++) begin
                if (j == int'(k) - 1) begin
                  vals[j] = byte_plain;
                end
              end
              n_emit = RES_BITS'(k);
            end
          end
        end
      end
      default: begin
        if (in_byte_i == CH_CR) begin
          state_o.mode = MODE_AFTER_CR;
        end else if (in_byte_i == CH_EQ) begin
          state_o.mode = MODE_ESC;
        end else begin
          vals[0]      = byte_plain;
          n_emit       = RES_BITS'(1);
          state_o.mode = MODE_NORMAL;
        end
      end
    endcase

    // Each pending byte is checked against the limit in parallel; the
    // saturated count before byte j is min(count + j, COUNT_MAX).
    d = '0;
    for (int j = 0; j < MAX_RES; j++) begin
      sum   = cnt_ext + CMP_BITS'(j);
      sat   = (sum > CMP_BITS'(COUNT_MAX)) ? CMP_BITS'(COUNT_MAX) : sum;
      ok[j] = !state_i.failed && (RES_BITS'(j) < n_emit) && (sat < exp_ext);
      d     = d + RES_BITS'(ok[j]);
    end
    too_many = !state_i.failed && (n_emit > d);

    for (int j = 0; j < MAX_RES; j++) begin
      list_o.ent[j].data = ok[j] ? vals[j] : 8'd0;
      list_o.ent[j].kind = ok[j] ? KIND_DATA : KIND_TOO_MANY;
    end
    list_o.n = d + RES_BITS'(too_many);

    sum_d          = cnt_ext + CMP_BITS'(d);
    sat_d          = (sum_d > CMP_BITS'(COUNT_MAX)) ? CMP_BITS'(COUNT_MAX) : sum_d;
    state_o.count  = sat_d[COUNT_BITS-1:0];
    state_o.failed = state_i.failed | too_many;

    if (end_hit) begin
      list_o.n           = state_i.failed ? RES_BITS'(0) : RES_BITS'(1);
      list_o.ent[0].data = 8'd0;
      list_o.ent[0].kind = (cnt_ext == exp_ext) ? KIND_END_OK : KIND_TOO_FEW;
      state_o.mode       = MODE_NORMAL;
      state_o.match_pos  = '0;
      state_o.count      = '0;
      state_o.failed     = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ sv/yenc_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module yenc_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  yenc_pkg::yenc_list_t list_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output yenc_pkg::yenc_res_t  out_res_o,
  output logic                 out_last_o
);
  import yenc_pkg::*;

  yenc_res_t [MAX_RES-1:0] ent_q, ent_d;
  logic [RES_BITS-1:0]     cnt_q, cnt_d;
  logic                    pop;
  logic                    load;

  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = ent_q[0];
  assign out_last_o  = (cnt_q == RES_BITS'(1));
  assign pop         = out_valid_o && out_ready_i;
  // A new request may enter while the final result of the previous one leaves.
  assign in_ready_o  = (cnt_q == '0) || (out_last_o && out_ready_i);
  assign load        = in_valid_i && in_ready_o;

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load) begin
      ent_d = list_i.ent;
      cnt_d = list_i.n;
    end else if (pop) begin
      for (int j = 0; j < MAX_RES - 1; j++) begin
        ent_d[j] = ent_q[j+1];
      end
      cnt_d = cnt_q - RES_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import yenc_pkg::*;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 300000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } res_t;

  typedef res_t res_list_t[$];

  typedef struct {
    mode_e                 mode;
    logic [2:0]            match_pos;
    logic [COUNT_BITS-1:0] count;
    bit                    failed;
    logic [CFG_BITS-1:0]   limit;
  } dec_state_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_BITS-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  dec_state_t body_state;
  res_t       pending_results[$];
  int         mismatches;
  int         sent_bytes;
  int         cycle_cnt;
  int         hold_cycles;
  int         idle_pct;
  int         stall_pct;

  yenc_body_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void add_res(inout res_list_t r, input logic [7:0] d, input kind_e k);
    res_t e;
    e.data = d;
    e.kind = k;
    e.last = 1'b0;
    r.insert(r.size(), e);
  endfunction

  function automatic void add_byte(inout byte_q_t f, input logic [7:0] b);
    f.insert(f.size(), b);
  endfunction

  // Decoded byte output: once the count has reached the limit a single too-many error
  // is reported and everything after it is swallowed until the end marker.
  function automatic void emit(inout dec_state_t s, inout res_list_t r, input logic [7:0] v);
    if (!s.failed) begin
      if (s.count >= s.limit) begin
        add_res(r, 8'h00, KIND_TOO_MANY);
        s.failed = 1'b1;
      end else begin
        add_res(r, v, KIND_DATA);
        if (s.count != COUNT_MAX) s.count++;
      end
    end
  endfunction

  function automatic void plain_byte(inout dec_state_t s, inout res_list_t r,
                                     input logic [7:0] b);
    if (b == CH_CR) begin
      s.mode = MODE_AFTER_CR;
    end else if (b == CH_EQ) begin
      s.mode = MODE_ESC;
    end else begin
      emit(s, r, b + PLAIN_OFS);
      s.mode = MODE_NORMAL;
    end
  endfunction

  function automatic res_list_t decode_byte(inout dec_state_t s, input logic [7:0] b);
    res_list_t r;
    int        k;
    int        i;
    kind_e     status;
    case (s.mode)
      MODE_ESC: begin
        emit(s, r, b + ESC_OFS);
        s.mode = MODE_NORMAL;
      end
      MODE_AFTER_CR: begin
        s.mode = MODE_LINE_START;
        s.match_pos = 3'd0;
      end
      MODE_FIRST: begin
        if (b == CH_EQ) begin
          s.mode = MODE_ESC;
        end else begin
          emit(s, r, b + PLAIN_OFS);
          s.mode = MODE_NORMAL;
        end
      end
      MODE_LINE_START: begin
        k = (s.match_pos > 3'd5) ? 5 : int'(s.match_pos);
        if (k == 0 && b == CH_DOT) begin
          s.mode = MODE_FIRST;
        end else if (b == END_MARKER[k]) begin
          s.match_pos = 3'(k + 1);
          if (k == MARKER_LEN - 1) begin
            if (!s.failed) begin
              status = (s.count == s.limit) ? KIND_END_OK : KIND_TOO_FEW;
              add_res(r, 8'h00, status);
            end
            s.mode = MODE_NORMAL;
            s.match_pos = 3'd0;
            s.count = '0;
            s.failed = 1'b0;
          end
        end else begin
          // The held '=' escapes the held 'y' if there is one, else the current byte.
          s.match_pos = 3'd0;
          s.mode = MODE_NORMAL;
          if (k == 0) begin
            emit(s, r, b + PLAIN_OFS);
          end else if (k == 1) begin
            emit(s, r, b + ESC_OFS);
          end else begin
            emit(s, r, END_MARKER[1] + ESC_OFS);
            for (i = 2; i < k; i++) emit(s, r, END_MARKER[i] + PLAIN_OFS);
            plain_byte(s, r, b);
          end
        end
      end
      default: plain_byte(s, r, b);
    endcase
    if (r.size() > 0) r[r.size() - 1].last = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] plain_raw();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CH_CR || b == CH_EQ) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic void append_marker(inout byte_q_t f);
    add_byte(f, CH_CR);
    add_byte(f, CH_LF);
    foreach (END_MARKER[i]) add_byte(f, END_MARKER[i]);
  endfunction

  // Mostly well-formed body content, with some odd breaks and plain noise mixed in.
  function automatic byte_q_t random_body(input int parts);
    byte_q_t f;
    int      p;
    int      j;
    int      k;
    for (p = 0; p < parts; p++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: add_byte(f, plain_raw());
        4: begin
          add_byte(f, CH_EQ);
          add_byte(f, 8'($urandom));
        end
        5: begin
          add_byte(f, CH_CR);
          add_byte(f, CH_LF);
        end
        6: begin
          add_byte(f, CH_CR);
          add_byte(f, CH_LF);
          add_byte(f, CH_DOT);
          add_byte(f, 8'($urandom));
        end
        7: begin
          k = $urandom_range(1, 5);
          add_byte(f, CH_CR);
          add_byte(f, CH_LF);
          for (j = 0; j < k; j++) add_byte(f, END_MARKER[j]);
          add_byte(f, 8'($urandom));
        end
        8: begin
          add_byte(f, CH_CR);
          add_byte(f, 8'($urandom));
        end
        default: add_byte(f, 8'($urandom));
      endcase
    end
    return f;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
  endtask

  task automatic send_seq(input byte_q_t f);
    foreach (f[i]) send_byte(f[i]);
  endtask

  // Bytes that cause no result may still be in flight once the queue is empty,
  // hence the settle time at the end.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_BITS-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One article body: the expected count is taken from what the body really yields,
  // then nudged now and then to provoke the too-many and too-few errors.
  task automatic run_frame(input int parts, input int hold, input int forced_limit);
    byte_q_t             frame;
    dec_state_t          scratch;
    res_list_t           r;
    logic [CFG_BITS-1:0] body_cnt;
    logic [CFG_BITS-1:0] lim;
    bit                  marked;
    frame = random_body(parts);
    if (forced_limit >= 0 || $urandom_range(7) != 0) append_marker(frame);
    wait_idle();
    scratch = body_state;
    scratch.limit = '1;
    scratch.failed = 1'b0;
    marked = 1'b0;
    body_cnt = '0;
    foreach (frame[i]) begin
      if (!marked) body_cnt = scratch.count;
      r = decode_byte(scratch, frame[i]);
      foreach (r[j]) if (r[j].kind != KIND_DATA) marked = 1'b1;
    end
    if (!marked) body_cnt = scratch.count;
    if (forced_limit >= 0) begin
      lim = CFG_BITS'(forced_limit);
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: lim = body_cnt;
        6, 7: lim = (body_cnt > 2) ? body_cnt - CFG_BITS'($urandom_range(1, 2)) : '0;
        8: lim = body_cnt + CFG_BITS'($urandom_range(1, 3));
        default: begin
          case ($urandom_range(2))
            0: lim = '0;
            1: lim = '1;
            default: lim = CFG_BITS'($urandom);
          endcase
        end
      endcase
    end
    write_limit(lim);
    hold_cycles = hold;
    send_seq(frame);
  endtask

  // Expected count still at its reset value of zero.
  task automatic test_reset_count();
    byte_q_t f;
    add_byte(f, 8'h00);
    append_marker(f);
    send_seq(f);
    wait_idle();
  endtask

  task automatic test_escapes_and_dots();
    byte_q_t f;
    f = '{8'hFF, CH_EQ, 8'h00, CH_EQ, 8'hFF, CH_CR, CH_LF, CH_DOT, CH_DOT};
    append_marker(f);
    write_limit(CFG_BITS'(5));
    send_seq(f);
    wait_idle();
  endtask

  task automatic test_random_bodies();
    int phase_idle[4];
    int phase_stall[4];
    int target;
    phase_idle  = '{0, 73, 0, 11};
    phase_stall = '{0, 0, 73, 11};
    foreach (phase_idle[p]) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      target = sent_bytes + 12;
      while (sent_bytes < target) run_frame($urandom_range(1, 6), 0, -1);
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // The receiver holds off long enough for the result buffer to fill up.
  task automatic test_backpressure();
    run_frame(12, 120, 24'hFFFFFF);
    run_frame(3, 0, 0);
    wait_idle();
  endtask

  // The sender stops halfway through a body until every result has drained.
  task automatic test_pause_mid_body();
    byte_q_t f;
    int      i;
    stall_pct = 30;
    write_limit(CFG_BITS'(12));
    for (i = 0; i < 6; i++) add_byte(f, plain_raw());
    send_seq(f);
    wait_idle();
    f.delete();
    for (i = 0; i < 6; i++) add_byte(f, plain_raw());
    append_marker(f);
    send_seq(f);
    wait_idle();
    stall_pct = 0;
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Requests are decoded before results are checked.
  always @(posedge clk_i) begin : scoreboard
    res_list_t produced;
    res_t      want;
    if (rst_ni) begin
      if (cfg_we_i) body_state.limit = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        produced = decode_byte(body_state, s_axis_tdata);
        foreach (produced[j]) pending_results.insert(pending_results.size(), produced[j]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: out_byte %0h kind %0d last %0b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    sent_bytes    = 0;
    cycle_cnt     = 0;
    hold_cycles   = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    body_state    = '{mode: MODE_NORMAL, match_pos: 3'd0, count: '0, failed: 1'b0,
                      limit: '0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_count();
    test_escapes_and_dots();
    test_random_bodies();
    test_backpressure();
    test_pause_mid_body();
    wait_idle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
